### hw/rtl/bitmap_frame_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top_macros
// Assertion macros used by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Field widths, request and status codes, and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

    localparam int MODE_W    = 2;
    localparam int FIRST_W   = 14;
    localparam int LEN_W     = 15;
    localparam int GRANT_W   = 14;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 1;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MARK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 1'b1;

    localparam logic [CFG_W-1:0] CFG_END_RESET = 15'd16384;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RUN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/bfa_req_if.sv
// ----------------------------------------------------------------------------
// bfa_req_if
// Request channel: mode, run start and run length.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfa_req_if;
    logic                          valid;
    logic                          ready;
    logic [bfa_pkg::MODE_W-1:0]    mode;
    logic [bfa_pkg::FIRST_W-1:0]   first_frame;
    logic [bfa_pkg::LEN_W-1:0]     run_length;

    modport source (output valid, output mode, output first_frame, output run_length,
                    input ready);
    modport sink   (input valid, input mode, input first_frame, input run_length,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/bfa_rsp_if.sv
// ----------------------------------------------------------------------------
// bfa_rsp_if
// Result channel: granted frame and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bfa_pkg::GRANT_W-1:0]    granted_frame;
    logic [bfa_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output granted_frame, output status, input ready);
    modport sink   (input valid, input granted_frame, input status, output ready);
endinterface

`default_nettype wire

### hw/rtl/bitmap_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// First-fit page-frame allocator over a used/free bitmap held in RAM.
// ----------------------------------------------------------------------------
// The bitmap lives in one RAM of WORD_BITS-wide words, W = FRAME_TOTAL /
// WORD_BITS words (rounded up), walked one word per cycle through the RAM
// read port. After reset a clearing pass over all W words zeroes the map; no
// request is taken meanwhile. Free and mark make one pass over the map; an
// allocate makes a scan pass, then a marking pass over the map once a run
// is found. Zero-length and rejected requests make no pass. One request at
// a time; a finished result waits in the output register while the next
// request is taken.
`default_nettype none

module bitmap_frame_allocator_top #(
    parameter int FRAME_TOTAL = 16384,
    parameter int WORD_BITS   = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    bfa_req_if.sink                              i_req,
    bfa_rsp_if.source                            o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [bfa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bfa_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int NW = (FRAME_TOTAL + WORD_BITS - 1) / WORD_BITS;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;
    localparam int FW = $clog2(FRAME_TOTAL + 65536 + 2 * WORD_BITS) + 1;
    localparam int LW = bfa_pkg::LEN_W;
    localparam logic [AW-1:0] LAST_W = AW'(NW - 1);

    function automatic logic [WORD_BITS-1:0] low_mask(input logic [FW-1:0] n);
        logic [WORD_BITS-1:0] m;
        for (int j = 0; j < WORD_BITS; j++) begin
            m[j] = (FW'(j) < n);
        end
        return m;
    endfunction

    function automatic logic [FW-1:0] sat_sub(input logic [FW-1:0] a,
                                              input logic [FW-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    bfa_pkg::t_state r_state, n_state;

    logic [bfa_pkg::CFG_W-1:0] r_cfg_first, n_cfg_first;
    logic [bfa_pkg::CFG_W-1:0] r_cfg_end, n_cfg_end;
    logic [AW-1:0]             r_rd, n_rd;
    logic                      r_rd_done, n_rd_done;
    logic                      r_pv, n_pv;
    logic                      r_ov, n_ov;
    logic [AW-1:0]             r_pw, n_pw;
    logic [FW-1:0]             r_base, n_base;
    logic [LW-1:0]             r_carry, n_carry;
    logic [FW-1:0]             r_rf, n_rf;
    logic [LW-1:0]             r_rl, n_rl;
    logic                      r_mark, n_mark;
    logic [bfa_pkg::GRANT_W-1:0]  r_rg, n_rg;
    logic [bfa_pkg::STATUS_W-1:0] r_rs, n_rs;
    logic [bfa_pkg::GRANT_W-1:0]  r_og, n_og;
    logic [bfa_pkg::STATUS_W-1:0] r_os, n_os;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd),
        .o_rdata (ram_rdata)
    );

    // per-word scan of free frames
    logic [FW-1:0]        end_cap;
    logic [WORD_BITS-1:0] free_bits, full_pre, hit;
    logic                 any_hit;
    logic [FW-1:0]        hit_pos;
    logic [FW-1:0]        top_free;
    logic [FW-1:0]        carry_sum;
    logic [LW-1:0]        carry_next;
    logic [FW-1:0]        grant_frame;
    logic [WORD_BITS-1:0] run_mask, win;
    logic [FW-1:0]        req_end;

    always_comb begin
        end_cap = (FW'(r_cfg_end) > FW'(FRAME_TOTAL)) ? FW'(FRAME_TOTAL) : FW'(r_cfg_end);
        free_bits = ~ram_rdata
                  & ~low_mask(sat_sub(FW'(r_cfg_first), r_base))
                  & low_mask(sat_sub(end_cap, r_base));
        for (int j = 0; j < WORD_BITS; j++) begin
            full_pre[j] = ((free_bits | ~low_mask(FW'(j + 1))) == '1);
            win = low_mask(FW'(j + 1)) & ~low_mask(FW'(j + 1) - FW'(r_rl));
            hit[j] = ((FW'(r_rl) <= FW'(j + 1)) && ((free_bits & win) == win))
                   || (full_pre[j] && (FW'(r_carry) + FW'(j + 1) >= FW'(r_rl)));
        end
        any_hit = |hit;
        hit_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (hit[j]) begin
                hit_pos = FW'(j);
            end
        end
        top_free = FW'(WORD_BITS);
        for (int j = 0; j < WORD_BITS; j++) begin
            if (!free_bits[j]) begin
                top_free = FW'(WORD_BITS - 1 - j);
            end
        end
        carry_sum = full_pre[WORD_BITS-1] ? (FW'(r_carry) + FW'(WORD_BITS)) : top_free;
        carry_next = (carry_sum > FW'(r_rl)) ? r_rl : LW'(carry_sum);
        grant_frame = r_base + hit_pos + FW'(1) - FW'(r_rl);
        req_end = r_rf + FW'(r_rl);
        run_mask = low_mask(sat_sub(req_end, r_base)) & ~low_mask(sat_sub(r_rf, r_base));
    end

    always_comb begin
        n_state     = r_state;
        n_cfg_first = r_cfg_first;
        n_cfg_end   = r_cfg_end;
        n_rd        = r_rd;
        n_rd_done   = r_rd_done;
        n_pv        = 1'b0;
        n_pw        = r_rd;
        n_base      = r_base;
        n_carry     = r_carry;
        n_rf        = r_rf;
        n_rl        = r_rl;
        n_mark      = r_mark;
        n_rg        = r_rg;
        n_rs        = r_rs;
        n_og        = r_og;
        n_os        = r_os;
        n_ov        = r_ov & ~o_rsp.ready;
        ram_we      = 1'b0;
        ram_waddr   = r_pw;
        ram_wdata   = r_mark ? (ram_rdata | run_mask) : (ram_rdata & ~run_mask);
        ram_re      = 1'b0;
        i_req.ready = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bfa_pkg::CFG_FIRST: n_cfg_first = i_cfg_data;
                bfa_pkg::CFG_END:   n_cfg_end   = i_cfg_data;
                default: ;
            endcase
        end

        if ((r_state == bfa_pkg::S_SCAN || r_state == bfa_pkg::S_RUN) && !r_rd_done) begin
            ram_re    = 1'b1;
            n_pv      = 1'b1;
            n_rd      = r_rd + AW'(1);
            n_rd_done = (r_rd == LAST_W);
        end

        unique case (r_state)
            bfa_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_rd;
                ram_wdata = '0;
                n_rd      = r_rd + AW'(1);
                if (r_rd == LAST_W) begin
                    n_state = bfa_pkg::S_IDLE;
                end
            end
            bfa_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                n_rd      = '0;
                n_rd_done = 1'b0;
                n_base    = '0;
                n_carry   = '0;
                n_rl      = i_req.run_length;
                n_rf      = FW'(i_req.first_frame);
                n_rg      = '0;
                n_rs      = bfa_pkg::ST_OK;
                n_mark    = (i_req.mode == bfa_pkg::MODE_MARK);
                if (i_req.valid) begin
                    priority if (i_req.mode == bfa_pkg::MODE_ALLOC) begin
                        if (i_req.run_length == '0) begin
                            n_rg    = r_cfg_first[bfa_pkg::GRANT_W-1:0];
                            n_state = bfa_pkg::S_DONE;
                        end else begin
                            n_state = bfa_pkg::S_SCAN;
                        end
                    end else if (i_req.mode == bfa_pkg::MODE_FREE
                              || i_req.mode == bfa_pkg::MODE_MARK) begin
                        if (FW'(i_req.first_frame) + FW'(i_req.run_length)
                                > FW'(FRAME_TOTAL)) begin
                            n_rs    = bfa_pkg::ST_BEYOND;
                            n_state = bfa_pkg::S_DONE;
                        end else if (i_req.run_length == '0) begin
                            n_state = bfa_pkg::S_DONE;
                        end else begin
                            n_state = bfa_pkg::S_RUN;
                        end
                    end else begin
                        n_rs    = bfa_pkg::ST_BEYOND;
                        n_state = bfa_pkg::S_DONE;
                    end
                end
            end
            bfa_pkg::S_SCAN: begin
                if (r_pv) begin
                    n_base  = r_base + FW'(WORD_BITS);
                    n_carry = carry_next;
                    if (any_hit) begin
                        n_rg      = grant_frame[bfa_pkg::GRANT_W-1:0];
                        n_rf      = grant_frame;
                        n_mark    = 1'b1;
                        n_base    = '0;
                        n_rd      = '0;
                        n_rd_done = 1'b0;
                        n_pv      = 1'b0;
                        n_state   = bfa_pkg::S_RUN;
                    end else if (r_pw == LAST_W) begin
                        n_rs    = bfa_pkg::ST_NOMEM;
                        n_state = bfa_pkg::S_DONE;
                    end
                end
            end
            bfa_pkg::S_RUN: begin
                if (r_pv) begin
                    ram_we = 1'b1;
                    n_base = r_base + FW'(WORD_BITS);
                    if (r_pw == LAST_W) begin
                        n_state = bfa_pkg::S_DONE;
                    end
                end
            end
            bfa_pkg::S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_og    = r_rg;
                    n_os    = r_rs;
                    n_ov    = 1'b1;
                    n_state = bfa_pkg::S_IDLE;
                end
            end
            default: n_state = bfa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfa_pkg::S_CLEAR;
            r_cfg_first <= '0;
            r_cfg_end   <= bfa_pkg::CFG_END_RESET;
            r_rd        <= '0;
            r_rd_done   <= 1'b0;
            r_pv        <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg_first <= n_cfg_first;
            r_cfg_end   <= n_cfg_end;
            r_rd        <= n_rd;
            r_rd_done   <= n_rd_done;
            r_pv        <= n_pv;
            r_ov        <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pw    <= n_pw;
        r_base  <= n_base;
        r_carry <= n_carry;
        r_rf    <= n_rf;
        r_rl    <= n_rl;
        r_mark  <= n_mark;
        r_rg    <= n_rg;
        r_rs    <= n_rs;
        r_og    <= n_og;
        r_os    <= n_os;
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.granted_frame = r_og;
    assign o_rsp.status        = r_os;

endmodule

`default_nettype wire

### hw/rtl/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_frame_allocator_top_macros.svh"

module bfa_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [bfa_pkg::GRANT_W-1:0]    i_granted_frame,
    input wire logic [bfa_pkg::STATUS_W-1:0]   i_status
);

    `BFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_granted_frame) && $stable(i_status))

    `BFA_ASSERT_NOW(a_status_code, i_clk, i_rst_n, i_out_valid,
        i_status == bfa_pkg::ST_OK || i_status == bfa_pkg::ST_NOMEM
        || i_status == bfa_pkg::ST_BEYOND)

    `BFA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n,
        i_out_valid && i_status != bfa_pkg::ST_OK, i_granted_frame == '0)

    `BFA_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready,
        !i_in_ready)

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_granted_frame (o_rsp.granted_frame),
    .i_status        (o_rsp.status)
);

`default_nettype wire
